// File: rtl/mcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_pkg: shared types, codes and control store of the tick scheduler
// Holds the action, modifier and result codes, the sequencer step and
// micro-operation types, and the control-store program itself.
// ----------------------------------------------------------------------------
package mcts_pkg;

    // Default number of clock slots and the slot space the 3-bit index can reach.
    localparam int NUM_CLOCKS_DEF = 8;
    localparam int SLOT_SPACE     = 8;

    // Input actions. Codes five to seven mean nothing and end in a bare done word.
    typedef enum logic [2:0] {
        ACT_UPDATE  = 3'd0,
        ACT_SET     = 3'd1,
        ACT_PAUSE   = 3'd2,
        ACT_UNPAUSE = 3'd3,
        ACT_RESYNC  = 3'd4
    } act_t;

    // Step modifier modes.
    typedef enum logic [1:0] {
        MOD_NONE  = 2'd0,
        MOD_FIXED = 2'd1,
        MOD_MUL   = 2'd2,
        MOD_MAX   = 2'd3
    } mod_t;

    // Result word kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] CFG_GMODE  = 1'b0;
    localparam logic [0:0] CFG_GVALUE = 1'b1;

    // Control-store addresses; sequential fall-through follows this order.
    typedef enum logic [4:0] {
        S_IDLE,
        S_GDIFF,
        S_GMUL,
        S_GMOD,
        S_SRD,
        S_SADD,
        S_SDIFF,
        S_SMUL,
        S_SMOD,
        S_STICK,
        S_SEMIT,
        S_SWB,
        S_SNEXT,
        S_DONE,
        S_SET,
        S_PAUSE,
        S_RSY
    } step_t;

    // Datapath micro-operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_GDIFF,
        OP_MUL,
        OP_GMOD,
        OP_SLOT_RD,
        OP_SLOT_ADD,
        OP_SLOT_DIFF,
        OP_SMOD,
        OP_SLOT_TICK,
        OP_EMIT_TICK,
        OP_SLOT_WB,
        OP_SLOT_NEXT,
        OP_EMIT_DONE,
        OP_SET,
        OP_PAUSE,
        OP_RESYNC
    } op_t;

    // Sequencing conditions.
    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_DISPATCH,
        C_IF_INACTIVE,
        C_IF_NOT_DUE,
        C_LOOP,
        C_WAIT_ROOM
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        op_t  op;
        logic accept;
    } ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic inactive;
        logic not_due;
        logic more;
        logic room;
    } flags_t;

    // The control store.
    function automatic ucode_t ucode(input step_t s);
        ucode_t w;
        w = '{op: OP_NONE, cond: C_GOTO, target: S_IDLE};
        case (s)
            S_IDLE:  w = '{op: OP_NONE,      cond: C_DISPATCH,    target: S_IDLE};
            S_GDIFF: w = '{op: OP_GDIFF,     cond: C_NEXT,        target: S_IDLE};
            S_GMUL:  w = '{op: OP_MUL,       cond: C_NEXT,        target: S_IDLE};
            S_GMOD:  w = '{op: OP_GMOD,      cond: C_NEXT,        target: S_IDLE};
            S_SRD:   w = '{op: OP_SLOT_RD,   cond: C_IF_INACTIVE, target: S_SNEXT};
            S_SADD:  w = '{op: OP_SLOT_ADD,  cond: C_NEXT,        target: S_IDLE};
            S_SDIFF: w = '{op: OP_SLOT_DIFF, cond: C_IF_NOT_DUE,  target: S_SWB};
            S_SMUL:  w = '{op: OP_MUL,       cond: C_NEXT,        target: S_IDLE};
            S_SMOD:  w = '{op: OP_SMOD,      cond: C_NEXT,        target: S_IDLE};
            S_STICK: w = '{op: OP_SLOT_TICK, cond: C_NEXT,        target: S_IDLE};
            S_SEMIT: w = '{op: OP_EMIT_TICK, cond: C_WAIT_ROOM,   target: S_SNEXT};
            S_SWB:   w = '{op: OP_SLOT_WB,   cond: C_NEXT,        target: S_IDLE};
            S_SNEXT: w = '{op: OP_SLOT_NEXT, cond: C_LOOP,        target: S_SRD};
            S_DONE:  w = '{op: OP_EMIT_DONE, cond: C_WAIT_ROOM,   target: S_IDLE};
            S_SET:   w = '{op: OP_SET,       cond: C_GOTO,        target: S_DONE};
            S_PAUSE: w = '{op: OP_PAUSE,     cond: C_GOTO,        target: S_DONE};
            S_RSY:   w = '{op: OP_RESYNC,    cond: C_LOOP,        target: S_RSY};
            default: w = '{op: OP_NONE,      cond: C_GOTO,        target: S_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of each action.
    function automatic step_t entry(input logic [2:0] action);
        step_t s;
        case (action)
            ACT_UPDATE:  s = S_GDIFF;
            ACT_SET:     s = S_SET;
            ACT_PAUSE:   s = S_PAUSE;
            ACT_UNPAUSE: s = S_PAUSE;
            ACT_RESYNC:  s = S_RSY;
            default:     s = S_DONE;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/mcts_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_mod: step modifier unit
// Registers the Q16.16 product and combinationally selects the modified step
// (none, fixed, saturated multiply from the registered product, or clamp).
// ----------------------------------------------------------------------------
module mcts_mod (
    input  logic        clk,
    input  logic        mul_en,
    input  logic [31:0] d,
    input  logic [1:0]  mode,
    input  logic [31:0] operand,
    output logic [31:0] res
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = {32'd0, operand} * {32'd0, d};

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        case (mode)
            mcts_pkg::MOD_NONE:  res = d;
            mcts_pkg::MOD_FIXED: res = operand;
            mcts_pkg::MOD_MUL:   res = (prod_reg[63:48] != 16'd0) ? 32'hFFFF_FFFF
                                                                  : prod_reg[47:16];
            mcts_pkg::MOD_MAX:   res = (operand < d) ? operand : d;
            default:             res = d;
        endcase
    end

endmodule

// File: rtl/mcts_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_seq: microcode sequencer
// Step counter over the control store, with dispatch on the action and
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mcts_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        action,
    input  mcts_pkg::flags_t  flags,
    output logic              in_stall,
    output mcts_pkg::ctrl_t   ctrl
);

    mcts_pkg::step_t  step_reg;
    mcts_pkg::step_t  step_next;
    mcts_pkg::ucode_t cw;
    mcts_pkg::step_t  step_inc;
    logic             idle;

    assign cw       = mcts_pkg::ucode(step_reg);
    assign idle     = (step_reg == mcts_pkg::S_IDLE);
    assign in_stall = !idle;
    assign step_inc = mcts_pkg::step_t'(5'(step_reg) + 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= mcts_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctrl.op     = cw.op;
        ctrl.accept = idle && in_valid;
        case (cw.cond)
            mcts_pkg::C_NEXT:        step_next = step_inc;
            mcts_pkg::C_GOTO:        step_next = cw.target;
            mcts_pkg::C_DISPATCH:    step_next = in_valid ? mcts_pkg::entry(action) : step_reg;
            mcts_pkg::C_IF_INACTIVE: step_next = flags.inactive ? cw.target : step_inc;
            mcts_pkg::C_IF_NOT_DUE:  step_next = flags.not_due ? cw.target : step_inc;
            mcts_pkg::C_LOOP:        step_next = flags.more ? cw.target : mcts_pkg::S_DONE;
            mcts_pkg::C_WAIT_ROOM:   step_next = flags.room ? cw.target : step_reg;
            default:                 step_next = mcts_pkg::S_IDLE;
        endcase
    end

    // An accepted word always starts a program.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> (step_reg != mcts_pkg::S_IDLE))
        else $error("sequencer stayed idle after accepting a word");

    // Loading the done word ends the program.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == mcts_pkg::OP_EMIT_DONE) && flags.room |=> idle)
        else $error("sequencer did not return to idle after the done word");

endmodule

// File: rtl/mcts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_dp: scheduler datapath
// Input and configuration registers, slot flags, slot field memories, the
// modifier unit and the output register, all driven by one micro-operation.
// ----------------------------------------------------------------------------
module mcts_dp #(
    parameter int NUM_CLOCKS = mcts_pkg::NUM_CLOCKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mcts_pkg::ctrl_t  ctrl,
    output mcts_pkg::flags_t flags,
    input  logic [2:0]       action,
    input  logic [31:0]      now_time,
    input  logic [2:0]       slot,
    input  logic             enable,
    input  logic [31:0]      period,
    input  logic [1:0]       mod_mode,
    input  logic [31:0]      mod_value,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [31:0]      cfg_wdata,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             kind,
    output logic [2:0]       tick_slot,
    output logic [31:0]      step_dt,
    output logic [31:0]      clock_now,
    output logic             last
);

    localparam int SLOTS = (NUM_CLOCKS < mcts_pkg::SLOT_SPACE) ? NUM_CLOCKS
                                                               : mcts_pkg::SLOT_SPACE;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic period;
        logic mode;
        logic oper;
        logic real_t;
        logic last_t;
        logic clock;
    } mem_we_t;

    // Latched input word.
    logic [2:0]  act_reg;
    logic [31:0] now_reg;
    logic [2:0]  slot_reg;
    logic        enable_reg;
    logic [31:0] period_reg;
    logic [1:0]  mmode_in_reg;
    logic [31:0] mval_reg;

    logic [1:0]  gmode_reg;
    logic [31:0] gvalue_reg;
    logic [31:0] prev_reg;

    logic [SLOTS-1:0] en_reg;
    logic [SLOTS-1:0] paused_reg;
    logic [AW-1:0]    cnt_reg;

    // Working registers.
    logic [31:0] d_reg;
    logic [1:0]  mmode_reg;
    logic [31:0] mop_reg;
    logic [31:0] dt_reg;
    logic [31:0] cdt_reg;
    logic [31:0] real_reg;
    logic [31:0] clock_reg;
    logic [31:0] mod_res;

    // Slot field memories and their registered read data.
    logic [31:0] mem_period [SLOTS];
    logic [1:0]  mem_mode   [SLOTS];
    logic [31:0] mem_oper   [SLOTS];
    logic [31:0] mem_real   [SLOTS];
    logic [31:0] mem_last   [SLOTS];
    logic [31:0] mem_clock  [SLOTS];
    logic [31:0] rd_period_reg;
    logic [1:0]  rd_mode_reg;
    logic [31:0] rd_oper_reg;
    logic [31:0] rd_real_reg;
    logic [31:0] rd_last_reg;
    logic [31:0] rd_clock_reg;

    mem_we_t     we;
    logic [AW-1:0] wa;
    logic [31:0] w_real;
    logic [31:0] w_last;
    logic [31:0] w_clock;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [2:0]  tick_slot_reg;
    logic [31:0] step_dt_reg;
    logic [31:0] clock_now_reg;
    logic        last_reg;

    logic          slot_ok;
    logic [AW-1:0] sidx;
    logic          room;
    logic [31:0]   elapsed;

    assign slot_ok = (4'(slot_reg) < 4'(SLOTS));
    assign sidx    = slot_reg[AW-1:0];
    assign room    = !out_valid_reg || !out_stall;
    assign elapsed = real_reg - rd_last_reg;

    assign flags.inactive = !en_reg[cnt_reg] || paused_reg[cnt_reg];
    assign flags.not_due  = (elapsed < rd_period_reg);
    assign flags.more     = (cnt_reg != AW'(SLOTS - 1));
    assign flags.room     = room;

    mcts_mod u_mod (
        .clk     (clk),
        .mul_en  (ctrl.op == mcts_pkg::OP_MUL),
        .d       (d_reg),
        .mode    (mmode_reg),
        .operand (mop_reg),
        .res     (mod_res)
    );

    // Control state: configuration, previous sample, slot flags, loop counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmode_reg  <= '0;
            gvalue_reg <= '0;
            prev_reg   <= '0;
            en_reg     <= '0;
            paused_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mcts_pkg::CFG_GMODE)
                begin
                    gmode_reg <= cfg_wdata[1:0];
                end
                else
                begin
                    gvalue_reg <= cfg_wdata;
                end
            end
            if (ctrl.accept)
            begin
                cnt_reg <= '0;
            end
            case (ctrl.op)
                mcts_pkg::OP_GDIFF:
                begin
                    prev_reg <= now_reg;
                end
                mcts_pkg::OP_SLOT_NEXT, mcts_pkg::OP_RESYNC:
                begin
                    if (flags.more)
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                    end
                end
                mcts_pkg::OP_SET:
                begin
                    if (slot_ok)
                    begin
                        if (!enable_reg)
                        begin
                            en_reg[sidx]     <= 1'b0;
                            paused_reg[sidx] <= 1'b0;
                        end
                        else if (!en_reg[sidx])
                        begin
                            en_reg[sidx]     <= 1'b1;
                            paused_reg[sidx] <= 1'b0;
                        end
                    end
                end
                mcts_pkg::OP_PAUSE:
                begin
                    if (slot_ok && en_reg[sidx])
                    begin
                        paused_reg[sidx] <= (act_reg == mcts_pkg::ACT_PAUSE);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload working registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            act_reg      <= action;
            now_reg      <= now_time;
            slot_reg     <= slot;
            enable_reg   <= enable;
            period_reg   <= period;
            mmode_in_reg <= mod_mode;
            mval_reg     <= mod_value;
        end
        case (ctrl.op)
            mcts_pkg::OP_GDIFF:
            begin
                d_reg     <= now_reg - prev_reg;
                mmode_reg <= gmode_reg;
                mop_reg   <= gvalue_reg;
            end
            mcts_pkg::OP_GMOD:
            begin
                dt_reg <= mod_res;
            end
            mcts_pkg::OP_SLOT_RD:
            begin
                rd_period_reg <= mem_period[cnt_reg];
                rd_mode_reg   <= mem_mode[cnt_reg];
                rd_oper_reg   <= mem_oper[cnt_reg];
                rd_real_reg   <= mem_real[cnt_reg];
                rd_last_reg   <= mem_last[cnt_reg];
                rd_clock_reg  <= mem_clock[cnt_reg];
            end
            mcts_pkg::OP_SLOT_ADD:
            begin
                real_reg <= rd_real_reg + dt_reg;
            end
            mcts_pkg::OP_SLOT_DIFF:
            begin
                d_reg     <= elapsed;
                mmode_reg <= rd_mode_reg;
                mop_reg   <= rd_oper_reg;
            end
            mcts_pkg::OP_SMOD:
            begin
                cdt_reg <= mod_res;
            end
            mcts_pkg::OP_SLOT_TICK:
            begin
                clock_reg <= rd_clock_reg + cdt_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Memory write selection.
    always_comb
    begin
        we      = '0;
        wa      = cnt_reg;
        w_real  = real_reg;
        w_last  = real_reg;
        w_clock = clock_reg;
        case (ctrl.op)
            mcts_pkg::OP_EMIT_TICK:
            begin
                we.real_t = 1'b1;
                we.last_t = 1'b1;
                we.clock  = 1'b1;
            end
            mcts_pkg::OP_SLOT_WB:
            begin
                we.real_t = 1'b1;
            end
            mcts_pkg::OP_SET:
            begin
                wa      = sidx;
                w_real  = '0;
                w_last  = '0;
                w_clock = '0;
                if (slot_ok && enable_reg)
                begin
                    we.period = 1'b1;
                    we.mode   = 1'b1;
                    we.oper   = 1'b1;
                    if (!en_reg[sidx])
                    begin
                        we.real_t = 1'b1;
                        we.last_t = 1'b1;
                        we.clock  = 1'b1;
                    end
                end
            end
            mcts_pkg::OP_RESYNC:
            begin
                w_real = prev_reg;
                w_last = prev_reg;
                if (en_reg[cnt_reg])
                begin
                    we.real_t = 1'b1;
                    we.last_t = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we.period)
        begin
            mem_period[wa] <= period_reg;
        end
        if (we.mode)
        begin
            mem_mode[wa] <= mmode_in_reg;
        end
        if (we.oper)
        begin
            mem_oper[wa] <= mval_reg;
        end
        if (we.real_t)
        begin
            mem_real[wa] <= w_real;
        end
        if (we.last_t)
        begin
            mem_last[wa] <= w_last;
        end
        if (we.clock)
        begin
            mem_clock[wa] <= w_clock;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (room && ((ctrl.op == mcts_pkg::OP_EMIT_TICK)
                          || (ctrl.op == mcts_pkg::OP_EMIT_DONE)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && (ctrl.op == mcts_pkg::OP_EMIT_TICK))
        begin
            kind_reg      <= mcts_pkg::KIND_TICK;
            tick_slot_reg <= 3'(cnt_reg);
            step_dt_reg   <= cdt_reg;
            clock_now_reg <= clock_reg;
            last_reg      <= 1'b0;
        end
        else if (room && (ctrl.op == mcts_pkg::OP_EMIT_DONE))
        begin
            kind_reg      <= mcts_pkg::KIND_DONE;
            tick_slot_reg <= '0;
            step_dt_reg   <= (act_reg == mcts_pkg::ACT_UPDATE) ? dt_reg : 32'd0;
            clock_now_reg <= '0;
            last_reg      <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tick_slot = tick_slot_reg;
    assign step_dt   = step_dt_reg;
    assign clock_now = clock_now_reg;
    assign last      = last_reg;

    // A paused slot is always an existing slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (paused_reg & ~en_reg) == '0)
        else $error("slot paused while not enabled");

    // Ticks come only from enabled, running slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == mcts_pkg::OP_EMIT_TICK) && room
            |-> en_reg[cnt_reg] && !paused_reg[cnt_reg])
        else $error("tick emitted for an inactive slot");

    // Only the done word closes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> (kind_reg == mcts_pkg::KIND_DONE))
        else $error("final word of an item is not a done word");

endmodule

// File: rtl/multi_clock_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_clock_tick_scheduler_unit: bank of software clocks with tick periods
// Top level: microcode sequencer, datapath with slot memories, modifier unit.
// ----------------------------------------------------------------------------
// The block handles one input word at a time; in_stall is low only while the
// sequencer sits at its idle step. Every word yields one or more result words
// and always ends with a done word (kind 1, last 1); an update word first
// yields one tick word per slot that reached its period, in slot order. With
// N = min(NUM_CLOCKS, 8) slots: set, pause and unpause run their step, then
// load the done word; resync walks the N slots first; an unknown action loads
// it at once. An update forms the global step (difference, multiply, modify),
// then per slot reads the slot, skips it when disabled or paused, adds the
// step and writes back when not due, and else multiplies, modifies, ticks and
// emits. The control-store program walks the slots one at a time through a
// single read port of the slot memories and a single shared multiplier. A
// stalled output register holds the program at its emit step until the word
// is taken. Configuration writes (global modifier mode at index 0, operand at
// index 1) are taken in any cycle and should be issued only while the block is
// idle.
// ----------------------------------------------------------------------------
module multi_clock_tick_scheduler_unit #(
    parameter int NUM_CLOCKS = mcts_pkg::NUM_CLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] now_time,
    input  logic [2:0]  slot,
    input  logic        enable,
    input  logic [31:0] period,
    input  logic [1:0]  mod_mode,
    input  logic [31:0] mod_value,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  tick_slot,
    output logic [31:0] step_dt,
    output logic [31:0] clock_now,
    output logic        last,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    mcts_pkg::ctrl_t  ctrl;
    mcts_pkg::flags_t flags;

    // The sequencer steps through the control store and dispatches on action.
    mcts_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .flags    (flags),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    // The datapath executes one micro-operation per cycle and reports status.
    mcts_dp #(
        .NUM_CLOCKS (NUM_CLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .action    (action),
        .now_time  (now_time),
        .slot      (slot),
        .enable    (enable),
        .period    (period),
        .mod_mode  (mod_mode),
        .mod_value (mod_value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .tick_slot (tick_slot),
        .step_dt   (step_dt),
        .clock_now (clock_now),
        .last      (last)
    );

endmodule
